[src/bffa_pkg.sv]
package bffa_pkg;

    localparam logic [31:0] HDR_FREE    = 32'hDEADBEEF;
    localparam logic [31:0] HDR_USED    = 32'hBEEFDEAD;
    localparam logic [31:0] ALLOC_HDR   = 32'd8;
    localparam logic [32:0] SPLIT_SPARE = 33'd32;
    localparam logic [31:0] MIN_BLOCK   = 32'd16;
    localparam logic [17:0] MIN_PAYLOAD = 18'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_BADPTR  = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic [31:0] wdata;
    } heap_req_t;

endpackage

[src/bffa_heap.sv]
module bffa_heap #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bffa_pkg::heap_req_t req,
    output logic [31:0]         rdata,
    output logic                ready
);
    import bffa_pkg::*;

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int IW = $clog2(HEAP_WORDS);
    localparam logic [31:0] HEAP_LEN = 32'(HEAP_WORDS * 4);
    localparam logic [IW-1:0] LAST_IDX = IW'(HEAP_WORDS - 1);

    logic [31:0]   mem [HEAP_WORDS];
    logic [31:0]   q_reg;
    logic          oob_reg;
    logic          ready_reg;
    logic [IW-1:0] clr_reg;
    logic          in_range;
    logic [IW-1:0] idx;
    logic [31:0]   clr_data;

    assign in_range = {2'b00, req.addr[31:2]} < HEAP_LEN[31:0] >> 2;
    assign idx = req.addr[IW+1:2];

    always_comb begin
        clr_data = '0;
        if (clr_reg == '0) begin
            clr_data = HDR_FREE;
        end else if (clr_reg == IW'(1)) begin
            clr_data = HEAP_LEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
            clr_reg <= '0;
        end else if (!ready_reg) begin
            if (clr_reg == LAST_IDX) begin
                ready_reg <= 1'b1;
            end
            clr_reg <= clr_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!ready_reg) begin
            mem[clr_reg] <= clr_data;
        end else if (req.we && in_range) begin
            mem[idx] <= req.wdata;
        end
        q_reg <= mem[idx];
        oob_reg <= !in_range;
    end

    assign rdata = oob_reg ? '0 : q_reg;
    assign ready = ready_reg;

endmodule

[src/best_fit_free_list_allocator.sv]
// Channel | Direction | Fields
// s_      | in        | s_tuser: action; s_tdata: request_bytes[16:0], block_address[32:17]
// m_      | out       | m_tuser: status; m_tdata: granted_address[15:0]
// After reset the heap memory is swept once before s_tready rises.
// An item walks the free list node by node and does header checks, splicing and
// coalescing, all through the single heap memory port.
// The walk of the free list sets its duration, which grows with the free blocks walked.
// A result waits in an output register; the next item may be taken meanwhile, but it
// is held in its last cycle until the previous result has left.
module best_fit_free_list_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_bytes[16:0], block_address[32:17], zeros
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // granted_address[15:0]
    output logic [2:0]  m_tuser    // status
);
    import bffa_pkg::*;

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam logic [32:0] HEAP_LEN = 33'(HEAP_WORDS * 4);
    localparam int WALK_LIMIT = HEAP_WORDS / 4 + 1;
    localparam int CW = $clog2(WALK_LIMIT + 1);

    typedef enum logic [19:0] {
        S_CLEAR  = 20'h00001, S_IDLE   = 20'h00002, S_F_CHK  = 20'h00004,
        S_F_MAG  = 20'h00008, S_F_SIZE = 20'h00010, S_W_ISS  = 20'h00020,
        S_W_MAG  = 20'h00040, S_W_SIZE = 20'h00080, S_W_NEXT = 20'h00100,
        S_A_POST = 20'h00200, S_F_POST = 20'h00400, S_WR     = 20'h00800,
        S_F_CN   = 20'h01000, S_F_CN1  = 20'h02000, S_F_CN2  = 20'h04000,
        S_F_CP   = 20'h08000, S_F_CP1  = 20'h10000, S_F_CP2  = 20'h20000,
        S_DONE   = 20'h40000
    } state_t;

    typedef enum logic [4:0] {
        WM_SPLIT = 5'b00001, WM_TAKE = 5'b00010, WM_FREE = 5'b00100,
        WM_NEXT  = 5'b01000, WM_PREV = 5'b10000
    } wmode_t;

    state_t      state_reg, state_next;
    wmode_t      wmode_reg, wmode_next;
    logic [2:0]  wstep_reg, wstep_next;
    logic        act_reg, act_next;
    logic [31:0] head_reg, head_next;
    logic [31:0] cur_reg, cur_next, pred_reg, pred_next;
    logic [31:0] best_reg, best_next, bsz_reg, bsz_next, bpred_reg, bpred_next;
    logic [31:0] bn_reg, bn_next, sz_reg, sz_next, need_reg, need_next;
    logic [31:0] off_reg, off_next, s_reg, s_next;
    logic [31:0] succ_reg, succ_next, sp_reg, sp_next;
    logic        pv_reg, pv_next, bv_reg, bv_next, bpv_reg, bpv_next;
    logic        sv_reg, sv_next, spv_reg, spv_next;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [2:0]  st_reg, st_next;
    logic [15:0] grant_reg, grant_next;
    logic        mv_reg, mv_next;

    heap_req_t   mreq;
    logic [31:0] q;
    logic        mem_ready;
    logic [31:0] w_addr, w_data;
    logic        w_en, w_last;
    logic [17:0] rnd;
    logic [31:0] bp, y;

    bffa_heap #(.HEAP_BYTES(HEAP_BYTES)) u_heap (
        .aclk(aclk), .aresetn(aresetn), .req(mreq), .rdata(q), .ready(mem_ready)
    );

    assign cnt_inc = cnt_reg + CW'(1);
    assign rnd = ({1'b0, s_tdata[16:0]} + 18'd3) & ~18'd3;
    assign bp = bpv_reg ? bpred_reg : pred_reg;
    assign y = best_reg + need_reg;

    always_comb begin
        w_addr = '0;
        w_data = '0;
        w_en = 1'b1;
        w_last = 1'b0;
        case (wmode_reg)
            WM_SPLIT: begin
                case (wstep_reg)
                    3'd0: begin w_addr = off_reg; w_data = HDR_FREE; end
                    3'd1: begin w_addr = off_reg + 32'd4; w_data = bsz_reg - need_reg; end
                    3'd2: begin w_addr = off_reg + 32'd8; w_data = succ_reg; end
                    3'd3: begin w_addr = off_reg + 32'd12; w_data = sp_reg; end
                    3'd4: begin
                        w_addr = sp_reg + 32'd8; w_data = off_reg; w_en = sp_reg != off_reg;
                    end
                    3'd5: begin
                        w_addr = succ_reg + 32'd12; w_data = off_reg; w_en = sp_reg != off_reg;
                    end
                    3'd6: begin w_addr = best_reg; w_data = HDR_USED; end
                    default: begin
                        w_addr = best_reg + 32'd4; w_data = need_reg; w_last = 1'b1;
                    end
                endcase
            end
            WM_TAKE: begin
                case (wstep_reg)
                    3'd0: begin w_addr = bpred_reg + 32'd8; w_data = bn_reg; end
                    3'd1: begin w_addr = bn_reg + 32'd12; w_data = bpred_reg; end
                    3'd2: begin w_addr = best_reg; w_data = HDR_USED; end
                    default: begin
                        w_addr = best_reg + 32'd4; w_data = bsz_reg; w_last = 1'b1;
                    end
                endcase
            end
            WM_FREE: begin
                case (wstep_reg)
                    3'd0: begin w_addr = off_reg; w_data = HDR_FREE; end
                    3'd1: begin w_addr = off_reg + 32'd4; w_data = s_reg; end
                    3'd2: begin w_addr = off_reg + 32'd8; w_data = succ_reg; end
                    3'd3: begin w_addr = off_reg + 32'd12; w_data = sp_reg; end
                    3'd4: begin w_addr = sp_reg + 32'd8; w_data = off_reg; end
                    default: begin
                        w_addr = succ_reg + 32'd12; w_data = off_reg; w_last = 1'b1;
                    end
                endcase
            end
            WM_NEXT: begin
                case (wstep_reg)
                    3'd0: begin w_addr = off_reg + 32'd4; w_data = s_reg; end
                    3'd1: begin w_addr = off_reg + 32'd8; w_data = bn_reg; end
                    default: begin
                        w_addr = bn_reg + 32'd12; w_data = off_reg; w_last = 1'b1;
                    end
                endcase
            end
            default: begin
                case (wstep_reg)
                    3'd0: begin w_addr = sp_reg + 32'd4; w_data = bsz_reg + s_reg; end
                    3'd1: begin w_addr = sp_reg + 32'd8; w_data = bn_reg; end
                    default: begin
                        w_addr = bn_reg + 32'd12; w_data = sp_reg; w_last = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        state_next = state_reg; wmode_next = wmode_reg; wstep_next = wstep_reg;
        act_next = act_reg; head_next = head_reg; cur_next = cur_reg;
        pred_next = pred_reg; best_next = best_reg; bsz_next = bsz_reg;
        bpred_next = bpred_reg; bn_next = bn_reg; sz_next = sz_reg;
        need_next = need_reg; off_next = off_reg; s_next = s_reg;
        succ_next = succ_reg; sp_next = sp_reg; pv_next = pv_reg; bv_next = bv_reg;
        bpv_next = bpv_reg; sv_next = sv_reg; spv_next = spv_reg; cnt_next = cnt_reg;
        st_next = st_reg; grant_next = grant_reg; mv_next = mv_reg;
        mreq = '{we: 1'b0, addr: cur_reg, wdata: '0};
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                if (mem_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next = s_tuser;
                    need_next = 32'(((rnd < MIN_PAYLOAD) ? MIN_PAYLOAD : rnd)) + ALLOC_HDR;
                    off_next = {16'd0, s_tdata[32:17]} - ALLOC_HDR;
                    cur_next = head_reg;
                    pv_next = 1'b0; bv_next = 1'b0; bpv_next = 1'b0;
                    sv_next = 1'b0; spv_next = 1'b0; cnt_next = '0;
                    grant_next = '0;
                    state_next = (s_tuser == ACT_ALLOC) ? S_W_ISS : S_F_CHK;
                end
            end
            S_F_CHK: begin
                mreq.addr = off_reg;
                if ({1'b0, off_reg} >= HEAP_LEN || off_reg[1:0] != 2'b00) begin
                    st_next = ST_BADPTR; state_next = S_DONE;
                end else begin
                    state_next = S_F_MAG;
                end
            end
            S_F_MAG: begin
                mreq.addr = off_reg + 32'd4;
                if (q != HDR_USED) begin
                    st_next = ST_NOTALLOC; state_next = S_DONE;
                end else begin
                    state_next = S_F_SIZE;
                end
            end
            S_F_SIZE: begin
                s_next = q;
                if (q < MIN_BLOCK || q[1:0] != 2'b00 || {1'b0, off_reg} + {1'b0, q} > HEAP_LEN)
                begin
                    st_next = ST_CORRUPT; state_next = S_DONE;
                end else begin
                    state_next = S_W_ISS;
                end
            end
            S_W_ISS: begin
                if (cur_reg[1:0] != 2'b00 || {1'b0, cur_reg} + 33'd16 > HEAP_LEN) begin
                    st_next = ST_CORRUPT; state_next = S_DONE;
                end else begin
                    state_next = S_W_MAG;
                end
            end
            S_W_MAG: begin
                mreq.addr = cur_reg + 32'd4;
                if (q != HDR_FREE) begin
                    st_next = ST_CORRUPT; state_next = S_DONE;
                end else begin
                    state_next = S_W_SIZE;
                end
            end
            S_W_SIZE: begin
                mreq.addr = cur_reg + 32'd8;
                sz_next = q;
                if (q < MIN_BLOCK || q[1:0] != 2'b00 || {1'b0, cur_reg} + {1'b0, q} > HEAP_LEN)
                begin
                    st_next = ST_CORRUPT; state_next = S_DONE;
                end else begin
                    state_next = S_W_NEXT;
                end
            end
            S_W_NEXT: begin
                if (act_reg == ACT_ALLOC) begin
                    if (sz_reg >= need_reg && (!bv_reg || sz_reg < bsz_reg)) begin
                        bv_next = 1'b1; best_next = cur_reg; bsz_next = sz_reg;
                        bpred_next = pred_reg; bpv_next = pv_reg; bn_next = q;
                    end
                end else if (!sv_reg && cur_reg > off_reg) begin
                    sv_next = 1'b1; succ_next = cur_reg; sp_next = pred_reg; spv_next = pv_reg;
                end
                pred_next = cur_reg; pv_next = 1'b1; cur_next = q; cnt_next = cnt_inc;
                if (q == head_reg) begin
                    state_next = (act_reg == ACT_ALLOC) ? S_A_POST : S_F_POST;
                end else if (32'(cnt_inc) >= 32'(WALK_LIMIT)) begin
                    st_next = ST_CORRUPT; state_next = S_DONE;
                end else begin
                    state_next = S_W_ISS;
                end
            end
            S_A_POST: begin
                bpred_next = bp;
                wstep_next = '0;
                st_next = ST_OK;
                grant_next = best_reg[15:0] + ALLOC_HDR[15:0];
                if (!bv_reg) begin
                    st_next = ST_NOFIT; grant_next = '0; state_next = S_DONE;
                end else if ({1'b0, bsz_reg} >= {1'b0, need_reg} + SPLIT_SPARE) begin
                    off_next = y;
                    sp_next = (bp == best_reg) ? y : bp;
                    succ_next = (bn_reg == best_reg) ? y : bn_reg;
                    if (best_reg == head_reg) begin
                        head_next = y;
                    end
                    wmode_next = WM_SPLIT; state_next = S_WR;
                end else if (cnt_reg == CW'(1)) begin
                    st_next = ST_NOFIT; grant_next = '0; state_next = S_DONE;
                end else begin
                    if (best_reg == head_reg) begin
                        head_next = bn_reg;
                    end
                    wmode_next = WM_TAKE; state_next = S_WR;
                end
            end
            S_F_POST: begin
                if (!sv_reg) begin
                    succ_next = head_reg; sp_next = pred_reg;
                end else if (!spv_reg) begin
                    sp_next = pred_reg;
                end
                if (off_reg < head_reg) begin
                    head_next = off_reg;
                end
                wstep_next = '0; wmode_next = WM_FREE; state_next = S_WR;
            end
            S_WR: begin
                mreq = '{we: w_en, addr: w_addr, wdata: w_data};
                wstep_next = wstep_reg + 3'd1;
                if (w_last) begin
                    wstep_next = '0;
                    case (wmode_reg)
                        WM_FREE: state_next = S_F_CN;
                        WM_NEXT: state_next = S_F_CP;
                        default: begin
                            st_next = ST_OK; state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_F_CN: begin
                mreq.addr = succ_reg + 32'd8;
                if (succ_reg > off_reg && {1'b0, off_reg} + {1'b0, s_reg} == {1'b0, succ_reg})
                begin
                    state_next = S_F_CN1;
                end else begin
                    state_next = S_F_CP;
                end
            end
            S_F_CN1: begin
                mreq.addr = succ_reg + 32'd4;
                bn_next = q;
                state_next = S_F_CN2;
            end
            S_F_CN2: begin
                s_next = s_reg + q;
                if (head_reg == succ_reg) begin
                    head_next = off_reg;
                end
                wmode_next = WM_NEXT; state_next = S_WR;
            end
            S_F_CP: begin
                mreq.addr = sp_reg + 32'd4;
                if (sp_reg < off_reg) begin
                    state_next = S_F_CP1;
                end else begin
                    st_next = ST_OK; state_next = S_DONE;
                end
            end
            S_F_CP1: begin
                mreq.addr = off_reg + 32'd8;
                bsz_next = q;
                if ({1'b0, sp_reg} + {1'b0, q} == {1'b0, off_reg}) begin
                    state_next = S_F_CP2;
                end else begin
                    st_next = ST_OK; state_next = S_DONE;
                end
            end
            S_F_CP2: begin
                bn_next = q;
                if (head_reg == off_reg) begin
                    head_next = sp_reg;
                end
                wmode_next = WM_PREV; state_next = S_WR;
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            wmode_reg <= WM_FREE;
            wstep_reg <= '0;
            head_reg <= '0;
            mv_reg <= 1'b0;
            st_reg <= ST_OK;
            grant_reg <= '0;
        end else begin
            state_reg <= state_next;
            wmode_reg <= wmode_next;
            wstep_reg <= wstep_next;
            head_reg <= head_next;
            mv_reg <= mv_next;
            if (state_reg != S_DONE || state_next == S_IDLE || !mv_reg) begin
                st_reg <= st_next;
                grant_reg <= (st_next == ST_OK) ? grant_next : 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg <= act_next; cur_reg <= cur_next; pred_reg <= pred_next;
        best_reg <= best_next; bsz_reg <= bsz_next; bpred_reg <= bpred_next;
        bn_reg <= bn_next; sz_reg <= sz_next; need_reg <= need_next;
        off_reg <= off_next; s_reg <= s_next; succ_reg <= succ_next; sp_reg <= sp_next;
        pv_reg <= pv_next; bv_reg <= bv_next; bpv_reg <= bpv_next;
        sv_reg <= sv_next; spv_reg <= spv_next; cnt_reg <= cnt_next;
    end

    logic [2:0]  ost_reg;
    logic [15:0] ogr_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!mv_reg || m_tready)) begin
            ost_reg <= st_reg;
            ogr_reg <= (st_reg == ST_OK) ? grant_reg : 16'd0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser = ost_reg;
    assign m_tdata = ogr_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");
    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == 16'd0)
        else $error("address granted with a failing status");
    a_head_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg[1:0] == 2'b00)
        else $error("free list head lost word alignment");
    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && state_next == S_IDLE |=> m_tvalid)
        else $error("finished item did not reach the output");

endmodule
